>>> sv/iirbq_pkg.sv
// Shared constants and types for the biquad cascade filter.
// No dependencies; imported by every module of the block.
`default_nettype none
package iirbq_pkg;
    localparam int TAPS      = 5;
    localparam int HIST_FRAC = 8;
    localparam int COEF_FRAC = 16;

    typedef enum logic [2:0] {
        TAP_B0 = 3'd0,
        TAP_B1 = 3'd1,
        TAP_B2 = 3'd2,
        TAP_A1 = 3'd3,
        TAP_A2 = 3'd4
    } tap_t;

    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_COEF   = 1'b1
    } func_t;

    // Coefficient write broadcast from the top level to the chain.
    typedef struct packed {
        logic       en;
        logic [5:0] section;
        logic [2:0] tap;
    } coef_wr_t;
endpackage
`default_nettype wire

>>> sv/iirbq_cell.sv
// One second-order section: coefficient store, history and a shared MAC.
// Depends on iirbq_pkg.
`default_nettype none
module iirbq_cell #(
    parameter int HW  = 24,
    parameter int CW  = 20,
    parameter int IDX = 0,
    parameter int SW  = 6
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire iirbq_pkg::coef_wr_t     coef_wr,
    input  wire logic signed [CW-1:0]    coef_data,
    input  wire logic                    start,
    input  wire logic                    active,
    input  wire logic signed [HW-1:0]    x_in,
    input  wire logic                    clip_in,
    output logic                         done,
    output logic signed [HW-1:0]         y_out,
    output logic                         clip_out
);
    import iirbq_pkg::*;

    localparam int PW = HW + CW;
    localparam int AW = PW + 3;

    logic signed [CW-1:0] coef_reg [TAPS];
    logic signed [HW-1:0] x1_reg, x2_reg, y1_reg, y2_reg, xin_reg;
    logic signed [HW-1:0] y_reg;
    logic                 clip_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic [2:0]           step_reg;   // tap being multiplied
    logic                 busy_reg, acc_vld_reg, sub_reg, last_reg, done_reg;

    logic signed [CW-1:0] c_sel;
    logic signed [HW-1:0] h_sel;
    logic signed [AW-1:0] acc_next, sum_r, sh;
    logic signed [AW-1:0] hi_lim, lo_lim;
    logic                 sat_hi, sat_lo;

    always_ff @(posedge clk)
    begin
        if (coef_wr.en && coef_wr.section == SW'(IDX) && coef_wr.tap < 3'(TAPS))
        begin
            coef_reg[coef_wr.tap] <= coef_data;
        end
    end

    always_comb
    begin
        case (step_reg)
            TAP_B0:  begin c_sel = coef_reg[0]; h_sel = xin_reg; end
            TAP_B1:  begin c_sel = coef_reg[1]; h_sel = x1_reg;  end
            TAP_B2:  begin c_sel = coef_reg[2]; h_sel = x2_reg;  end
            TAP_A1:  begin c_sel = coef_reg[3]; h_sel = y1_reg;  end
            TAP_A2:  begin c_sel = coef_reg[4]; h_sel = y2_reg;  end
            default: begin c_sel = '0;          h_sel = '0;      end
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (acc_vld_reg)
        begin
            acc_next = sub_reg ? acc_reg - AW'(prod_reg) : acc_reg + AW'(prod_reg);
        end
        sum_r  = acc_next + AW'(1 <<< (COEF_FRAC - 1));
        sh     = sum_r >>> COEF_FRAC;
        hi_lim = AW'((64'sd1 <<< (HW - 1)) - 1);
        lo_lim = -hi_lim - AW'(1);
        sat_hi = sh > hi_lim;
        sat_lo = sh < lo_lim;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; acc_vld_reg <= 1'b0; last_reg <= 1'b0; done_reg <= 1'b0;
            step_reg <= '0;
            x1_reg <= '0; x2_reg <= '0; y1_reg <= '0; y2_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (active)
                begin
                    busy_reg <= 1'b1;
                    step_reg <= TAP_B0;
                    acc_reg  <= '0;
                    xin_reg  <= x_in;
                    clip_reg <= clip_in;
                end
                else
                begin
                    // Pass the word through untouched; history holds.
                    y_reg    <= x_in;
                    clip_reg <= clip_in;
                    done_reg <= 1'b1;
                end
            end
            if (busy_reg)
            begin
                prod_reg    <= c_sel * h_sel;
                sub_reg     <= step_reg >= TAP_A1;
                acc_vld_reg <= 1'b1;
                last_reg    <= step_reg == TAP_A2;
                if (step_reg == TAP_A2)
                begin
                    busy_reg <= 1'b0;
                end
                step_reg <= step_reg + 3'd1;
            end
            else
            begin
                acc_vld_reg <= 1'b0;
                last_reg    <= 1'b0;
            end
            if (acc_vld_reg)
            begin
                acc_reg <= acc_next;
            end
            if (last_reg)
            begin
                // Round half up, saturate, advance history.
                y_reg    <= sat_hi ? hi_lim[HW-1:0] : (sat_lo ? lo_lim[HW-1:0] : sh[HW-1:0]);
                clip_reg <= clip_reg | sat_hi | sat_lo;
                x2_reg   <= x1_reg;
                x1_reg   <= xin_reg;
                y2_reg   <= y1_reg;
                y1_reg   <= sat_hi ? hi_lim[HW-1:0] : (sat_lo ? lo_lim[HW-1:0] : sh[HW-1:0]);
                done_reg <= 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign y_out    = y_reg;
    assign clip_out = clip_reg;
endmodule
`default_nettype wire

>>> sv/iir_biquad_cascade_filter.sv
// Top level: stream wrapper, section count register and chain of biquad cells.
// Depends on iirbq_pkg and iirbq_cell.
// Only one sample is in the chain at a time; the next word is taken once its result is loaded into the output register.
// A result waiting for the output register holds off input; a coefficient word is written into its cell when taken.
// Reset: asynchronous, active low; clears history, control and sets 9 sections.
`default_nettype none
module iir_biquad_cascade_filter #(
    parameter int MAX_SECTIONS = 16,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 20
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata,       // sections_used
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: sample_in, coef_section, coef_tap, coef_value (from bit 0 up)
    input  wire logic [SAMPLE_WIDTH+4+3+COEF_WIDTH+((8-((SAMPLE_WIDTH+7+COEF_WIDTH)%8))%8)-1:0]
                             s_axis_tdata,
    input  wire logic        s_axis_tuser,    // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: filtered_out, clipped (from bit 0 up)
    output logic [SAMPLE_WIDTH+1+((8-((SAMPLE_WIDTH+1)%8))%8)-1:0] m_axis_tdata
);
    import iirbq_pkg::*;

    localparam int HW = SAMPLE_WIDTH + HIST_FRAC;
    localparam int SECW = $clog2(MAX_SECTIONS + 1);
    localparam int OWP  = $bits(m_axis_tdata);

    logic [4:0]  sections_reg;
    logic        busy_reg;
    logic        pend_reg;
    logic        out_vld_reg;
    logic [OWP-1:0] out_data_reg;
    logic [SECW-1:0] n_eff;
    logic        load;

    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic [3:0]                     coef_section;
    logic [2:0]                     coef_tap;
    logic signed [COEF_WIDTH-1:0]   coef_value;
    logic                           accept;
    coef_wr_t                       coef_wr;

    logic signed [HW-1:0] x_chain [MAX_SECTIONS+1];
    logic                 c_chain [MAX_SECTIONS+1];
    logic                 s_chain [MAX_SECTIONS+1];

    assign sample_in    = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign coef_section = s_axis_tdata[SAMPLE_WIDTH+3:SAMPLE_WIDTH];
    assign coef_tap     = s_axis_tdata[SAMPLE_WIDTH+6:SAMPLE_WIDTH+4];
    assign coef_value   = s_axis_tdata[SAMPLE_WIDTH+7+COEF_WIDTH-1:SAMPLE_WIDTH+7];

    // Hold off new words while a sample is in the chain or its result has not
    // reached the output register yet.
    assign s_axis_tready = !busy_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign coef_wr.en      = accept && s_axis_tuser == FUNC_COEF
                             && 32'(coef_section) < MAX_SECTIONS;
    assign coef_wr.section = 6'(coef_section);
    assign coef_wr.tap     = coef_tap;

    // Clamp the section count to 1..MAX_SECTIONS.
    always_comb
    begin
        if (sections_reg == 5'd0)
            n_eff = SECW'(1);
        else if (32'(sections_reg) > MAX_SECTIONS)
            n_eff = SECW'(MAX_SECTIONS);
        else
            n_eff = SECW'(sections_reg);
    end

    assign x_chain[0] = HW'(sample_in) <<< HIST_FRAC;
    assign c_chain[0] = 1'b0;
    assign s_chain[0] = accept && s_axis_tuser == FUNC_SAMPLE;

    for (genvar k = 0; k < MAX_SECTIONS; k++)
    begin : g_sec
        iirbq_cell #(.HW(HW), .CW(COEF_WIDTH), .IDX(k), .SW(6)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .coef_wr   (coef_wr),
            .coef_data (coef_value),
            .start     (s_chain[k]),
            .active    (k < 32'(n_eff)),
            .x_in      (x_chain[k]),
            .clip_in   (c_chain[k]),
            .done      (s_chain[k+1]),
            .y_out     (x_chain[k+1]),
            .clip_out  (c_chain[k+1])
        );
    end

    // Final rounding to sample width.
    logic signed [HW:0] rnd;
    logic signed [HW:0] shv;
    logic signed [HW:0] o_hi, o_lo;
    logic               o_sat_hi, o_sat_lo;
    logic [SAMPLE_WIDTH-1:0] o_val;
    always_comb
    begin
        rnd      = (HW+1)'(x_chain[MAX_SECTIONS]) + (HW+1)'(1 <<< (HIST_FRAC - 1));
        shv      = rnd >>> HIST_FRAC;
        o_hi     = (HW+1)'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
        o_lo     = -o_hi - (HW+1)'(1);
        o_sat_hi = shv > o_hi;
        o_sat_lo = shv < o_lo;
        o_val    = o_sat_hi ? o_hi[SAMPLE_WIDTH-1:0]
                 : (o_sat_lo ? o_lo[SAMPLE_WIDTH-1:0] : shv[SAMPLE_WIDTH-1:0]);
    end

    // Move a finished sample into the output register once it is free; until
    // then the last cell holds its word and the sample stays pending.
    assign load = (s_chain[MAX_SECTIONS] || pend_reg) && (!out_vld_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sections_reg <= 5'd9;
            busy_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                sections_reg <= cfg_wdata;
            if (s_chain[0])
                busy_reg <= 1'b1;
            else if (load)
                busy_reg <= 1'b0;
            if (load)
                pend_reg <= 1'b0;
            else if (s_chain[MAX_SECTIONS])
                pend_reg <= 1'b1;
            if (load)
                out_vld_reg <= 1'b1;
            else if (m_axis_tready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= OWP'({c_chain[MAX_SECTIONS] | o_sat_hi | o_sat_lo, o_val});
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !s_axis_tready) else $error("accept while busy");
    a_done_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_chain[MAX_SECTIONS] |-> busy_reg) else $error("result without sample");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !m_axis_tready |=> out_vld_reg) else $error("result dropped");
`endif
endmodule
`default_nettype wire
